[sv/ipv4f_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4f_pkg
// Types, codes and helpers shared by the IPv4 receive header filter.
// ----------------------------------------------------------------------------
package ipv4f_pkg;

  // verdict codes, in the order in which the checks apply
  typedef enum logic [3:0] {
    V_ACCEPT   = 4'd0,
    V_SHORT    = 4'd1,
    V_VERSION  = 4'd2,
    V_HDRLEN   = 4'd3,
    V_TOTLEN   = 4'd4,
    V_CHECKSUM = 4'd5,
    V_FRAGMENT = 4'd6,
    V_MARTIAN  = 4'd7,
    V_NOT_OURS = 4'd8
  } verdict_e;

  // layer-4 handler selection
  typedef enum logic [1:0] {
    L4_ICMP = 2'd0,
    L4_UDP  = 2'd1,
    L4_TCP  = 2'd2,
    L4_NONE = 2'd3
  } l4_target_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOCAL_ADDR        = 2'd0,
    CFG_SUBNET_MASK       = 2'd1,
    CFG_IS_LOOPBACK       = 2'd2,
    CFG_MULTICAST_CAPABLE = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // header constants
  localparam logic [3:0]  IpVersion4   = 4'h4;
  localparam logic [15:0] MinHdrBytes  = 16'd20;
  localparam logic [31:0] AllOnes      = 32'hFFFF_FFFF;
  localparam logic [31:0] AllHostsGrp  = 32'hE000_0001;
  localparam logic [7:0]  LoopNet      = 8'd127;
  localparam logic [3:0]  McastNibble  = 4'hE;
  localparam logic [15:0] CsumGood     = 16'hFFFF;
  localparam logic [13:0] FragNone     = 14'h0000;
  localparam logic [7:0]  ProtoIcmp    = 8'd1;
  localparam logic [7:0]  ProtoUdp     = 8'd17;
  localparam logic [7:0]  ProtoTcp     = 8'd6;

  // header word positions
  localparam logic [3:0]  WordFrag     = 4'd1;
  localparam logic [3:0]  WordProto    = 4'd2;
  localparam logic [3:0]  WordSrc      = 4'd3;
  localparam logic [3:0]  WordDst      = 4'd4;

  // request queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [31:0] local_addr;
    logic [31:0] subnet_mask;
    logic        is_loopback;
    logic        multicast_capable;
  } cfg_t;

  // one classified header word
  typedef struct packed {
    logic        first;      // opens a new packet
    verdict_e    fw_code;    // first-word length/version verdict
    logic [3:0]  ihl;        // header length in words
    logic [15:0] tot_len;    // total length field
    logic [15:0] wsum;       // one's-complement sum of both halves
    logic        frag;       // offset or more-fragments set, as word 1
    logic [7:0]  proto;      // protocol byte, as word 2
    logic        martian;    // word is a martian source, as word 3
    logic        dst_ok;     // word is an accepted destination, as word 4
    logic        dst_bcast;  // word is a broadcast destination, as word 4
  } rec_t;

  // end-around-carry add of two 16-bit values
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

[sv/ipv4f_if.sv]
// ----------------------------------------------------------------------------
// ipv4f channels
// Ready/valid channels for header words in and verdicts out.
// ----------------------------------------------------------------------------
interface ipv4f_in_if;
  logic        valid;
  logic        ready;
  logic        first_word;
  logic [31:0] header_word;
  logic [15:0] avail_len;
  logic        group_joined;
  logic        dst_is_own_addr;

  modport source (
    output valid, first_word, header_word, avail_len, group_joined, dst_is_own_addr,
    input  ready
  );
  modport sink (
    input  valid, first_word, header_word, avail_len, group_joined, dst_is_own_addr,
    output ready
  );
endinterface

interface ipv4f_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [1:0]  l4_target;
  logic        for_broadcast;
  logic [7:0]  protocol_num;
  logic [5:0]  header_bytes;
  logic [15:0] l4_len;

  modport source (
    output valid, verdict, l4_target, for_broadcast, protocol_num, header_bytes,
           l4_len,
    input  ready
  );
  modport sink (
    input  valid, verdict, l4_target, for_broadcast, protocol_num, header_bytes,
           l4_len,
    output ready
  );
endinterface

[sv/ipv4f_front.sv]
// ----------------------------------------------------------------------------
// ipv4f_front
// Accepts header words and classifies each one independently of packet state.
// ----------------------------------------------------------------------------
module ipv4f_front (
  ipv4f_in_if.sink         in_ch,
  input  ipv4f_pkg::cfg_t  cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output ipv4f_pkg::rec_t  rec_o
);
  import ipv4f_pkg::*;

  logic [31:0] w;
  logic [31:0] link_bcast;
  logic [5:0]  hlen;
  logic [15:0] hlen16;
  logic [15:0] tot;
  logic [15:0] avail;
  logic        bc;
  logic        lo;
  logic        mc_ok;
  logic        is_mc;
  verdict_e    fw_code;

  assign w = in_ch.header_word;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i;

  // first-word length and version checks
  assign hlen   = {w[27:24], 2'b00};
  assign hlen16 = {10'd0, hlen};
  assign tot    = w[15:0];
  assign avail  = in_ch.avail_len;

  always_comb begin
    if (avail < MinHdrBytes) begin
      fw_code = V_SHORT;
    end else if (w[31:28] != IpVersion4) begin
      fw_code = V_VERSION;
    end else if (hlen16 < MinHdrBytes || hlen16 > avail) begin
      fw_code = V_HDRLEN;
    end else if (tot > avail || tot < hlen16) begin
      fw_code = V_TOTLEN;
    end else begin
      fw_code = V_ACCEPT;
    end
  end

  assign rec_o.fw_code = fw_code;

  // address tests, valid when this word is the source or destination
  assign link_bcast = (cfg_i.local_addr & cfg_i.subnet_mask) | ~cfg_i.subnet_mask;
  assign is_mc      = (w[31:28] == McastNibble);

  always_comb begin
    lo = cfg_i.is_loopback &&
         ((w[31:24] == LoopNet) || ((w != '0) && in_ch.dst_is_own_addr));
    if (cfg_i.is_loopback) begin
      mc_ok = in_ch.group_joined;
    end else begin
      mc_ok = cfg_i.multicast_capable && ((w == AllHostsGrp) || in_ch.group_joined);
    end
    bc = (w == AllOnes) || ((cfg_i.subnet_mask != '0) && (w == link_bcast)) ||
         (is_mc && mc_ok);
  end

  assign rec_o.dst_bcast = bc;
  assign rec_o.dst_ok    = (w == cfg_i.local_addr) || bc || lo;
  assign rec_o.martian   = (w == '0) || is_mc || (w == AllOnes) ||
                           ((w[31:24] == LoopNet) && !cfg_i.is_loopback) ||
                           ((cfg_i.subnet_mask != '0) && (w == link_bcast));

  // remaining fields
  assign rec_o.first   = in_ch.first_word;
  assign rec_o.ihl     = w[27:24];
  assign rec_o.tot_len = tot;
  assign rec_o.wsum    = oc_add(w[31:16], w[15:0]);
  assign rec_o.frag    = (w[13:0] != FragNone);
  assign rec_o.proto   = w[23:16];

endmodule

[sv/ipv4f_queue.sv]
// ----------------------------------------------------------------------------
// ipv4f_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module ipv4f_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ipv4f_pkg::rec_t  rec_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output ipv4f_pkg::rec_t  head_o
);
  import ipv4f_pkg::*;

  rec_t             store_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign full_o       = (count_q == QCntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = store_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

[sv/ipv4f_back.sv]
// ----------------------------------------------------------------------------
// ipv4f_back
// Tracks header progress, folds the checksum and registers the verdict.
// ----------------------------------------------------------------------------
module ipv4f_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ipv4f_pkg::rec_t  head_i,
  output logic             pop_o,
  ipv4f_out_if.source      out_ch
);
  import ipv4f_pkg::*;

  logic        skipping_q, skipping_d;
  logic [3:0]  word_index_q, word_index_d;
  logic [3:0]  header_words_q, header_words_d;
  logic [15:0] total_len_q, total_len_d;
  logic [15:0] csum_q, csum_d;
  logic        frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic        martian_q, martian_d;
  logic        dst_ok_q, dst_ok_d;
  logic        dst_bcast_q, dst_bcast_d;
  logic        out_valid_q, out_valid_d;

  logic        res_valid;
  verdict_e    res_verdict;
  l4_target_e  res_l4;
  logic        res_bcast;
  logic [7:0]  res_proto;
  logic [5:0]  res_hbytes;
  logic [15:0] res_plen;
  logic [4:0]  next_index;

  // take a word when the output register is free or being emptied
  assign pop_o      = head_valid_i && (!out_valid_q || out_ch.ready);
  assign next_index = {1'b0, word_index_q} + 5'd1;

  always_comb begin
    skipping_d     = skipping_q;
    word_index_d   = word_index_q;
    header_words_d = header_words_q;
    total_len_d    = total_len_q;
    csum_d         = csum_q;
    frag_d         = frag_q;
    proto_d        = proto_q;
    martian_d      = martian_q;
    dst_ok_d       = dst_ok_q;
    dst_bcast_d    = dst_bcast_q;
    res_valid      = 1'b0;
    res_verdict    = V_ACCEPT;
    res_l4         = L4_NONE;
    res_bcast      = 1'b0;
    res_proto      = '0;
    res_hbytes     = '0;
    res_plen       = '0;

    if (pop_o) begin
      if (head_i.first) begin
        // new packet restarts the header
        frag_d      = 1'b0;
        proto_d     = '0;
        martian_d   = 1'b1;
        dst_ok_d    = 1'b0;
        dst_bcast_d = 1'b0;
        if (head_i.fw_code != V_ACCEPT) begin
          res_valid   = 1'b1;
          res_verdict = head_i.fw_code;
          skipping_d  = 1'b1;
        end else begin
          header_words_d = head_i.ihl;
          total_len_d    = head_i.tot_len;
          csum_d         = head_i.wsum;
          word_index_d   = 4'd1;
          skipping_d     = 1'b0;
        end
      end else if (!skipping_q) begin
        csum_d = oc_add(csum_q, head_i.wsum);
        // capture the field carried by this word
        case (word_index_q)
          WordFrag:  frag_d = head_i.frag;
          WordProto: proto_d = head_i.proto;
          WordSrc:   martian_d = head_i.martian;
          WordDst: begin
            dst_ok_d    = head_i.dst_ok;
            dst_bcast_d = head_i.dst_bcast;
          end
          default: ;
        endcase

        if (next_index < {1'b0, header_words_q}) begin
          word_index_d = next_index[3:0];
        end else begin
          // last header word: final checks
          skipping_d = 1'b1;
          res_valid  = 1'b1;
          if (csum_d != CsumGood) begin
            res_verdict = V_CHECKSUM;
          end else if (frag_d) begin
            res_verdict = V_FRAGMENT;
          end else if (martian_d) begin
            res_verdict = V_MARTIAN;
          end else if (!dst_ok_d) begin
            res_verdict = V_NOT_OURS;
          end else begin
            res_verdict = V_ACCEPT;
            res_bcast   = dst_bcast_d;
            res_proto   = proto_d;
            res_hbytes  = {header_words_q, 2'b00};
            res_plen    = total_len_q - {10'd0, header_words_q, 2'b00};
            case (proto_d)
              ProtoIcmp: res_l4 = L4_ICMP;
              ProtoUdp:  res_l4 = L4_UDP;
              ProtoTcp:  res_l4 = dst_bcast_d ? L4_NONE : L4_TCP;
              default:   res_l4 = L4_NONE;
            endcase
          end
        end
      end
    end

    // output register occupancy
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skipping_q     <= 1'b1;
      word_index_q   <= '0;
      header_words_q <= '0;
      total_len_q    <= '0;
      csum_q         <= '0;
      frag_q         <= 1'b0;
      proto_q        <= '0;
      martian_q      <= 1'b1;
      dst_ok_q       <= 1'b0;
      dst_bcast_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      skipping_q     <= skipping_d;
      word_index_q   <= word_index_d;
      header_words_q <= header_words_d;
      total_len_q    <= total_len_d;
      csum_q         <= csum_d;
      frag_q         <= frag_d;
      proto_q        <= proto_d;
      martian_q      <= martian_d;
      dst_ok_q       <= dst_ok_d;
      dst_bcast_q    <= dst_bcast_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_ch.verdict       <= res_verdict;
      out_ch.l4_target     <= res_l4;
      out_ch.for_broadcast <= res_bcast;
      out_ch.protocol_num  <= res_proto;
      out_ch.header_bytes  <= res_hbytes;
      out_ch.l4_len        <= res_plen;
    end
  end

  assign out_ch.valid = out_valid_q;

endmodule

[sv/ipv4_receive_header_filter.sv]
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// Checks an IPv4 header word by word and gives one verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries 32-bit header words, first byte in bits 31:24; first_word
//   opens a packet and avail_len is sampled with it, the two destination
//   flags with header word 4. out_ch carries one verdict per packet: on the
//   first word for length and version faults, otherwise on the last header
//   word. Words of a rejected packet up to the next first_word give nothing.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no packet is in flight.
// Timing:
//   One word per cycle sustained while out_ch is not stalled. A word enters
//   a four-entry queue at its accept edge; the back end takes it when the
//   output register is free or draining, and registers the deciding verdict.
// Reset and stall:
//   Reset zeroes the configuration, empties queue and output, and idles the
//   parser until a first word. A stalled receiver holds the verdict; words
//   keep being accepted until the queue is full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ipv4f_in_if.sink                    in_ch,
  ipv4f_out_if.source                 out_ch,
  input  logic                        cfg_we_i,
  input  logic [ipv4f_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipv4f_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ipv4f_pkg::*;

  cfg_t cfg_q;
  logic push;
  logic pop;
  logic q_full;
  logic head_valid;
  rec_t rec;
  rec_t head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_ADDR:        cfg_q.local_addr <= cfg_wdata_i;
        CFG_SUBNET_MASK:       cfg_q.subnet_mask <= cfg_wdata_i;
        CFG_IS_LOOPBACK:       cfg_q.is_loopback <= cfg_wdata_i[0];
        CFG_MULTICAST_CAPABLE: cfg_q.multicast_capable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // word classification
  ipv4f_front u_front (
    .in_ch    (in_ch),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .rec_o    (rec)
  );

  // request queue
  ipv4f_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rec_i        (rec),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // header tracking and verdict
  ipv4f_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule
